// ===== rtl/core/cemg_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the two-circle enclosing merge pipeline.
package cemg_pkg;

	// Fixed-point fraction bits of coordinates and radii
	localparam int FRAC_BITS = 16;

	// Pipelined square root: one result bit per stage, 64-bit radicand
	localparam int SQRT_LAT = 32;

	// Pipelined divider: one quotient bit per stage, Q1.30 quotient
	localparam int DIV_LAT = 31;

	// Unit vector component of one in Q1.30
	localparam logic [30:0] UNIT_ONE = 31'h4000_0000;

	// Largest radius value
	localparam logic [30:0] RAD_MAX = 31'h7FFF_FFFF;

endpackage

// ===== rtl/core/cemg_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, floor of the root of a 64-bit value.
module cemg_sqrt
	import cemg_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] radicand,
	output logic [31:0] root
);

	logic [63:0] rad_s  [SQRT_LAT];
	logic [35:0] rem_s  [SQRT_LAT];
	logic [31:0] root_s [SQRT_LAT];

	genvar k;
	for (k = 0; k < SQRT_LAT; k++) begin : g_stage
		logic [63:0] rad_in;
		logic [35:0] rem_in;
		logic [35:0] rem_sh;
		logic [35:0] trial;
		logic [31:0] root_in;
		logic        ge;

		if (k == 0) begin : g_first
			assign rad_in  = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		// Bring down the next bit pair and try the next root bit
		assign rem_sh = {rem_in[33:0], rad_in[63:62]};
		assign trial  = {2'b00, root_in, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {rad_in[61:0], 2'b00};
				rem_s[k]  <= ge ? (rem_sh - trial) : rem_sh;
				root_s[k] <= {root_in[30:0], ge};
			end
		end
	end

	assign root = root_s[SQRT_LAT-1];

endmodule

// ===== rtl/core/cemg_div.sv =====
`timescale 1ns / 1ps
// Pipelined divider giving floor(mag * 2^30 / den) for mag not above den.
module cemg_div
	import cemg_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] mag,
	input  logic [31:0] den,
	output logic [30:0] quo
);

	logic [31:0] rem_s [DIV_LAT];
	logic [31:0] den_s [DIV_LAT];
	logic [30:0] quo_s [DIV_LAT];

	genvar k;
	for (k = 0; k < DIV_LAT; k++) begin : g_stage
		logic [31:0] rem_in;
		logic [31:0] den_in;
		logic [30:0] quo_in;
		logic        nbit;
		logic [32:0] rem_sh;
		logic [32:0] diff;
		logic        ge;

		// Dividend is mag shifted up by 30: only its lowest bit enters late
		if (k == 0) begin : g_first
			assign rem_in = {2'b00, mag[30:1]};
			assign den_in = den;
			assign quo_in = '0;
			assign nbit   = mag[0];
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
			assign nbit   = 1'b0;
		end

		// Shift in one dividend bit and subtract when it fits
		assign rem_sh = {rem_in, nbit};
		assign diff   = rem_sh - {1'b0, den_in};
		assign ge     = (rem_sh >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[31:0] : rem_sh[31:0];
				den_s[k] <= den_in;
				quo_s[k] <= {quo_in[29:0], ge};
			end
		end
	end

	assign quo = quo_s[DIV_LAT-1];

endmodule

// ===== rtl/core/two_circle_enclosing_merge.sv =====
`timescale 1ns / 1ps
// The pipeline has 113 stages, from the input capture to the output register.
// Takes one item per cycle while the output does not stall; the sqrt and divider stages are fully pipelined.
// An output stall freezes the whole pipeline, and the input stalls with it.
// Reset (arst_n low, asynchronous) clears all valid bits; data registers hold junk.
// Top level: merge two circles into the circle through their far points.
module two_circle_enclosing_merge
	import cemg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] center_a_x,
	input  logic signed [31:0] center_a_y,
	input  logic        [30:0] radius_a,
	input  logic signed [31:0] center_b_x,
	input  logic signed [31:0] center_b_y,
	input  logic        [30:0] radius_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] merged_x,
	output logic signed [31:0] merged_y,
	output logic        [30:0] merged_radius,
	output logic               degenerate
);

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic        [30:0] ra;
		logic        [30:0] rb;
		logic        [30:0] rmax;
		logic               dxn;
		logic               dyn;
		logic               degen;
	} side_t;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic               sat;
	} mid_t;

	localparam logic [33:0] RND_HALF = 34'(1) << (FRAC_BITS - 1);
	localparam logic [33:0] RND_MASK = ~((34'(1) << FRAC_BITS) - 34'(1));
	localparam logic signed [34:0] C_MAX = 35'sh0_7FFF_FFFF;
	localparam logic signed [34:0] C_MIN = 35'sh7_8000_0000;

	// Clamp a coordinate to the signed 32-bit range
	function automatic logic [31:0] clamp_c(input logic signed [34:0] v);
		logic [31:0] r;
		if (v > C_MAX) begin
			r = C_MAX[31:0];
		end else if (v < C_MIN) begin
			r = C_MIN[31:0];
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Far point: base moved by the offset, toward or away from the other circle
	function automatic logic [33:0] far_pt(input logic [31:0] base, input logic [31:0] off,
		input logic sub);
		logic [33:0] b34;
		logic [33:0] o34;
		b34 = {{2{base[31]}}, base};
		o34 = {2'b00, off};
		return sub ? (b34 - o34) : (b34 + o34);
	endfunction

	logic en;

	// Stage registers
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic               v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16;
	logic               v_s17;
	side_t              side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	side_t              side_s7, side_s8, side_s9, side_s10, side_s11, side_s12, side_s13;
	side_t              side_s14, side_s15, side_s16, side_s17;
	logic signed [32:0] dx_s1, dy_s1;
	logic        [32:0] mx_s2, my_s2;
	logic        [30:0] mx_s3, my_s3, mx_s4, my_s4, mx_s5, my_s5, mx_s6, my_s6;
	logic        [61:0] sqx_s5, sqy_s5;
	logic        [62:0] sum_s6;

	logic               v_l1_s    [SQRT_LAT];
	side_t              side_l1_s [SQRT_LAT];
	logic        [30:0] mx_l1_s   [SQRT_LAT];
	logic        [30:0] my_l1_s   [SQRT_LAT];
	logic               v_l2_s    [DIV_LAT];
	side_t              side_l2_s [DIV_LAT];
	logic               v_l3_s    [SQRT_LAT];
	side_t              side_l3_s [SQRT_LAT];
	mid_t               mid_l3_s  [SQRT_LAT];

	logic        [31:0] len;
	logic        [30:0] quo_x, quo_y;
	logic        [30:0] ux_s7, uy_s7;
	logic        [61:0] prod_s8 [4];
	logic        [31:0] off_s9  [4];
	logic        [33:0] fp_s10  [4];
	logic        [33:0] mag_s11 [4];
	logic               neg_s11 [4];
	logic        [33:0] rq_s12  [4];
	logic               neg_s12 [4];
	logic signed [34:0] pr_s13  [4];
	logic signed [34:0] cx_s14, cy_s14, ex_s14, ey_s14;
	mid_t               mid_s15, mid_s16, mid_s17;
	logic        [30:0] mex_s15, mey_s15;
	logic        [61:0] sqx_s16, sqy_s16;
	logic        [62:0] sum_s17;
	logic        [31:0] rad_root;

	logic               out_valid_q;
	logic signed [31:0] merged_x_q, merged_y_q;
	logic        [30:0] merged_radius_q;
	logic               degenerate_q;

	// Advance everything unless the output holds an untaken item
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
			v_s17 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SQRT_LAT; i++) begin
				v_l1_s[i] <= 1'b0;
				v_l3_s[i] <= 1'b0;
			end
			for (int i = 0; i < DIV_LAT; i++) begin
				v_l2_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_l1_s[0] <= v_s6;
			for (int i = 1; i < SQRT_LAT; i++) begin
				v_l1_s[i] <= v_l1_s[i-1];
			end
			v_l2_s[0] <= v_l1_s[SQRT_LAT-1];
			for (int i = 1; i < DIV_LAT; i++) begin
				v_l2_s[i] <= v_l2_s[i-1];
			end
			v_s7  <= v_l2_s[DIV_LAT-1];
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
			v_s17 <= v_s16;
			v_l3_s[0] <= v_s17;
			for (int i = 1; i < SQRT_LAT; i++) begin
				v_l3_s[i] <= v_l3_s[i-1];
			end
			out_valid_q <= v_l3_s[SQRT_LAT-1];
		end
	end

	// Stage 1: capture the item and take the center difference
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.ax    <= center_a_x;
			side_s1.ay    <= center_a_y;
			side_s1.bx    <= center_b_x;
			side_s1.by    <= center_b_y;
			side_s1.ra    <= radius_a;
			side_s1.rb    <= radius_b;
			side_s1.rmax  <= (radius_a > radius_b) ? radius_a : radius_b;
			side_s1.dxn   <= 1'b0;
			side_s1.dyn   <= 1'b0;
			side_s1.degen <= 1'b0;
			dx_s1 <= {center_b_x[31], center_b_x} - {center_a_x[31], center_a_x};
			dy_s1 <= {center_b_y[31], center_b_y} - {center_a_y[31], center_a_y};
		end
	end

	// Stage 2: magnitudes, signs and the coincident-center flag
	side_t side_c2;
	always_comb begin
		side_c2       = side_s1;
		side_c2.dxn   = dx_s1[32];
		side_c2.dyn   = dy_s1[32];
		side_c2.degen = (dx_s1 == '0) && (dy_s1 == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_c2;
			mx_s2 <= dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
			my_s2 <= dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
		end
	end

	// Stage 3: scale down below 2^31, then coarse left shifts by 16 and 8
	logic [32:0] or_s3;
	logic [30:0] nx0, ny0, nx1, ny1, nx2, ny2;
	logic [30:0] o0, o1;
	always_comb begin
		or_s3 = mx_s2 | my_s2;
		if (or_s3[32]) begin
			nx0 = mx_s2[32:2];
			ny0 = my_s2[32:2];
		end else if (or_s3[31]) begin
			nx0 = mx_s2[31:1];
			ny0 = my_s2[31:1];
		end else begin
			nx0 = mx_s2[30:0];
			ny0 = my_s2[30:0];
		end
		o0  = nx0 | ny0;
		nx1 = (o0[30:15] == '0) ? {nx0[14:0], 16'b0} : nx0;
		ny1 = (o0[30:15] == '0) ? {ny0[14:0], 16'b0} : ny0;
		o1  = nx1 | ny1;
		nx2 = (o1[30:23] == '0) ? {nx1[22:0], 8'b0} : nx1;
		ny2 = (o1[30:23] == '0) ? {ny1[22:0], 8'b0} : ny1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			mx_s3   <= nx2;
			my_s3   <= ny2;
		end
	end

	// Stage 4: fine left shifts by 4, 2 and 1 until bit 30 of the larger is set
	logic [30:0] nx3, ny3, nx4, ny4, nx5, ny5;
	logic [30:0] o2, o3, o4;
	always_comb begin
		o2  = mx_s3 | my_s3;
		nx3 = (o2[30:27] == '0) ? {mx_s3[26:0], 4'b0} : mx_s3;
		ny3 = (o2[30:27] == '0) ? {my_s3[26:0], 4'b0} : my_s3;
		o3  = nx3 | ny3;
		nx4 = (o3[30:29] == '0) ? {nx3[28:0], 2'b0} : nx3;
		ny4 = (o3[30:29] == '0) ? {ny3[28:0], 2'b0} : ny3;
		o4  = nx4 | ny4;
		nx5 = !o4[30] ? {nx4[29:0], 1'b0} : nx4;
		ny5 = !o4[30] ? {ny4[29:0], 1'b0} : ny4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			mx_s4   <= nx5;
			my_s4   <= ny5;
		end
	end

	// Stage 5: square the scaled components
	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			mx_s5   <= mx_s4;
			my_s5   <= my_s4;
			sqx_s5  <= 62'(mx_s4) * 62'(mx_s4);
			sqy_s5  <= 62'(my_s4) * 62'(my_s4);
		end
	end

	// Stage 6: squared length
	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= side_s5;
			mx_s6   <= mx_s5;
			my_s6   <= my_s5;
			sum_s6  <= {1'b0, sqx_s5} + {1'b0, sqy_s5};
		end
	end

	// Length of the scaled difference
	cemg_sqrt u_len_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand ({1'b0, sum_s6}),
		.root     (len)
	);

	// Carry item data alongside the length root
	always_ff @(posedge clk) begin
		if (en) begin
			side_l1_s[0] <= side_s6;
			mx_l1_s[0]   <= mx_s6;
			my_l1_s[0]   <= my_s6;
			for (int i = 1; i < SQRT_LAT; i++) begin
				side_l1_s[i] <= side_l1_s[i-1];
				mx_l1_s[i]   <= mx_l1_s[i-1];
				my_l1_s[i]   <= my_l1_s[i-1];
			end
		end
	end

	// Unit vector components in Q1.30
	cemg_div u_div_x (
		.clk (clk),
		.en  (en),
		.mag (mx_l1_s[SQRT_LAT-1]),
		.den (len),
		.quo (quo_x)
	);

	cemg_div u_div_y (
		.clk (clk),
		.en  (en),
		.mag (my_l1_s[SQRT_LAT-1]),
		.den (len),
		.quo (quo_y)
	);

	// Carry item data alongside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			side_l2_s[0] <= side_l1_s[SQRT_LAT-1];
			for (int i = 1; i < DIV_LAT; i++) begin
				side_l2_s[i] <= side_l2_s[i-1];
			end
		end
	end

	// Stage 7: clamp unit components to one
	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= side_l2_s[DIV_LAT-1];
			ux_s7   <= (quo_x > UNIT_ONE) ? UNIT_ONE : quo_x;
			uy_s7   <= (quo_y > UNIT_ONE) ? UNIT_ONE : quo_y;
		end
	end

	// Stage 8: radius times unit component; lanes are A.x, A.y, B.x, B.y
	always_ff @(posedge clk) begin
		if (en) begin
			side_s8    <= side_s7;
			prod_s8[0] <= 62'(side_s7.ra) * 62'(ux_s7);
			prod_s8[1] <= 62'(side_s7.ra) * 62'(uy_s7);
			prod_s8[2] <= 62'(side_s7.rb) * 62'(ux_s7);
			prod_s8[3] <= 62'(side_s7.rb) * 62'(uy_s7);
		end
	end

	// Stage 9: round the products back to Q15.16 offsets
	always_ff @(posedge clk) begin
		if (en) begin
			side_s9 <= side_s8;
			for (int i = 0; i < 4; i++) begin
				off_s9[i] <= 32'((prod_s8[i] + 62'(1) * (62'(1) << 29)) >> 30);
			end
		end
	end

	// Stage 10: far points, A pushed away from B and B pushed away from A
	always_ff @(posedge clk) begin
		if (en) begin
			side_s10  <= side_s9;
			fp_s10[0] <= far_pt(side_s9.ax, off_s9[0], !side_s9.dxn);
			fp_s10[1] <= far_pt(side_s9.ay, off_s9[1], !side_s9.dyn);
			fp_s10[2] <= far_pt(side_s9.bx, off_s9[2], side_s9.dxn);
			fp_s10[3] <= far_pt(side_s9.by, off_s9[3], side_s9.dyn);
		end
	end

	// Stage 11: split far points into sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			side_s11 <= side_s10;
			for (int i = 0; i < 4; i++) begin
				neg_s11[i] <= fp_s10[i][33];
				mag_s11[i] <= fp_s10[i][33] ? (34'(0) - fp_s10[i]) : fp_s10[i];
			end
		end
	end

	// Stage 12: round magnitudes to whole units, half away from zero
	always_ff @(posedge clk) begin
		if (en) begin
			side_s12 <= side_s11;
			for (int i = 0; i < 4; i++) begin
				neg_s12[i] <= neg_s11[i];
				rq_s12[i]  <= (mag_s11[i] + RND_HALF) & RND_MASK;
			end
		end
	end

	// Stage 13: restore signs
	always_ff @(posedge clk) begin
		if (en) begin
			side_s13 <= side_s12;
			for (int i = 0; i < 4; i++) begin
				pr_s13[i] <= neg_s12[i] ? -$signed({1'b0, rq_s12[i]}) : $signed({1'b0, rq_s12[i]});
			end
		end
	end

	// Stage 14: midpoint and half span; sums are even so the halving is exact
	logic signed [35:0] sx, sy, hx, hy;
	always_comb begin
		sx = {pr_s13[0][34], pr_s13[0]} + {pr_s13[2][34], pr_s13[2]};
		sy = {pr_s13[1][34], pr_s13[1]} + {pr_s13[3][34], pr_s13[3]};
		hx = {pr_s13[2][34], pr_s13[2]} - {pr_s13[0][34], pr_s13[0]};
		hy = {pr_s13[3][34], pr_s13[3]} - {pr_s13[1][34], pr_s13[1]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s14 <= side_s13;
			cx_s14   <= sx[35:1];
			cy_s14   <= sy[35:1];
			ex_s14   <= hx[35:1];
			ey_s14   <= hy[35:1];
		end
	end

	// Stage 15: clamp the center, take half-span magnitudes, flag overflow
	logic [34:0] mex, mey;
	always_comb begin
		mex = ex_s14[34] ? 35'(-ex_s14) : 35'(ex_s14);
		mey = ey_s14[34] ? 35'(-ey_s14) : 35'(ey_s14);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s15    <= side_s14;
			mid_s15.cx  <= clamp_c(cx_s14);
			mid_s15.cy  <= clamp_c(cy_s14);
			mid_s15.sat <= (mex[34:31] != '0) || (mey[34:31] != '0);
			mex_s15     <= mex[30:0];
			mey_s15     <= mey[30:0];
		end
	end

	// Stage 16: square the half spans
	always_ff @(posedge clk) begin
		if (en) begin
			side_s16 <= side_s15;
			mid_s16  <= mid_s15;
			sqx_s16  <= 62'(mex_s15) * 62'(mex_s15);
			sqy_s16  <= 62'(mey_s15) * 62'(mey_s15);
		end
	end

	// Stage 17: squared radius
	always_ff @(posedge clk) begin
		if (en) begin
			side_s17 <= side_s16;
			mid_s17  <= mid_s16;
			sum_s17  <= {1'b0, sqx_s16} + {1'b0, sqy_s16};
		end
	end

	// Radius root
	cemg_sqrt u_rad_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand ({1'b0, sum_s17}),
		.root     (rad_root)
	);

	// Carry item data alongside the radius root
	always_ff @(posedge clk) begin
		if (en) begin
			side_l3_s[0] <= side_s17;
			mid_l3_s[0]  <= mid_s17;
			for (int i = 1; i < SQRT_LAT; i++) begin
				side_l3_s[i] <= side_l3_s[i-1];
				mid_l3_s[i]  <= mid_l3_s[i-1];
			end
		end
	end

	// Output register: pick the coincident-center answer or the merged circle
	side_t side_o;
	mid_t  mid_o;
	assign side_o = side_l3_s[SQRT_LAT-1];
	assign mid_o  = mid_l3_s[SQRT_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			degenerate_q <= side_o.degen;
			if (side_o.degen) begin
				merged_x_q      <= side_o.ax;
				merged_y_q      <= side_o.ay;
				merged_radius_q <= side_o.rmax;
			end else begin
				merged_x_q <= mid_o.cx;
				merged_y_q <= mid_o.cy;
				if (mid_o.sat || (rad_root > {1'b0, RAD_MAX})) begin
					merged_radius_q <= RAD_MAX;
				end else begin
					merged_radius_q <= rad_root[30:0];
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign merged_x      = merged_x_q;
	assign merged_y      = merged_y_q;
	assign merged_radius = merged_radius_q;
	assign degenerate    = degenerate_q;

	// Normalization leaves bit 30 set in the larger component
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !side_s4.degen |-> (mx_s4[30] || my_s4[30]))
		else $error("scaled difference not normalized");

	// Rounded far points in lanes A.x and B.y are whole units
	a_round: assert property (@(posedge clk) disable iff (!arst_n)
		v_s13 |-> (pr_s13[0][FRAC_BITS-1:0] == '0) && (pr_s13[3][FRAC_BITS-1:0] == '0))
		else $error("far point not rounded to whole units");

	// A held output freezes the pipeline
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(v_s17) && $stable(v_l2_s[0]))
		else $error("pipeline moved while output held");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the two-circle enclosing merge, with a scoreboard and a predictor.
module tb_top
	import cemg_pkg::*;
();

	localparam int RANDOM_ITEMS = 1700;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 150;

	typedef struct {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic        [30:0] ra;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic        [30:0] rb;
	} circle_pair_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic        [30:0] rad;
		logic               deg;
	} merged_circle_t;

	// Merged-circle predictor and queue of expected merges
	class merge_scoreboard;
		merged_circle_t expected_merges[$];
		int errors;
		int checked;
		int degenerate_seen;

		function automatic logic [63:0] isqrt(logic [63:0] n);
			logic [63:0] res;
			logic [63:0] bit_v;
			res = 0;
			bit_v = 64'd1 << 62;
			while (bit_v > n)
				bit_v = bit_v >> 2;
			while (bit_v != 0) begin
				if (n >= res + bit_v) begin
					n = n - (res + bit_v);
					res = (res >> 1) + bit_v;
				end else begin
					res = res >> 1;
				end
				bit_v = bit_v >> 2;
			end
			return res;
		endfunction

		function automatic logic [63:0] mag(longint v);
			return v < 0 ? 64'(-v) : 64'(v);
		endfunction

		function automatic longint offset(logic [63:0] r, logic [63:0] u, longint dir);
			longint o;
			o = longint'((r * u + (64'd1 << 29)) >> 30);
			return dir < 0 ? -o : o;
		endfunction

		// round to whole units, halves away from zero
		function automatic longint round_whole(longint v);
			logic [63:0] q;
			q = ((mag(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS) << FRAC_BITS;
			return v < 0 ? -longint'(q) : longint'(q);
		endfunction

		function automatic logic signed [31:0] clamp32(longint v);
			if (v > 64'sh7FFF_FFFF)
				return 32'sh7FFF_FFFF;
			if (v < -64'sh8000_0000)
				return 32'sh8000_0000;
			return v[31:0];
		endfunction

		function automatic merged_circle_t predict(circle_pair_t c);
			merged_circle_t m;
			longint ax, ay, bx, by, dx, dy;
			longint p1x, p1y, p2x, p2y, cx, cy, ex, ey;
			logic [63:0] mx, my, mm, len, ux, uy, mex, mey, rad;
			ax = longint'(c.ax);
			ay = longint'(c.ay);
			bx = longint'(c.bx);
			by = longint'(c.by);
			dx = bx - ax;
			dy = by - ay;
			// coincident centers: keep center A and the larger radius
			if (dx == 0 && dy == 0) begin
				m.x = c.ax;
				m.y = c.ay;
				m.rad = (c.ra > c.rb) ? c.ra : c.rb;
				m.deg = 1'b1;
				return m;
			end
			// normalize the direction so its larger component sits in [2^30, 2^31)
			mx = mag(dx);
			my = mag(dy);
			mm = (mx > my) ? mx : my;
			while (mm >= (64'd1 << 31)) begin
				mx = mx >> 1;
				my = my >> 1;
				mm = mm >> 1;
			end
			while (mm < (64'd1 << 30)) begin
				mx = mx << 1;
				my = my << 1;
				mm = mm << 1;
			end
			len = isqrt(mx * mx + my * my);
			ux = (mx << 30) / len;
			uy = (my << 30) / len;
			if (ux > UNIT_ONE)
				ux = UNIT_ONE;
			if (uy > UNIT_ONE)
				uy = UNIT_ONE;
			// far points on each circle
			p1x = round_whole(ax - offset(c.ra, ux, dx));
			p1y = round_whole(ay - offset(c.ra, uy, dy));
			p2x = round_whole(bx + offset(c.rb, ux, dx));
			p2y = round_whole(by + offset(c.rb, uy, dy));
			cx = (p1x + p2x) / 2;
			cy = (p1y + p2y) / 2;
			ex = (p2x - p1x) / 2;
			ey = (p2y - p1y) / 2;
			mex = mag(ex);
			mey = mag(ey);
			if (mex >= (64'd1 << 31) || mey >= (64'd1 << 31)) begin
				rad = RAD_MAX;
			end else begin
				rad = isqrt(mex * mex + mey * mey);
				if (rad > RAD_MAX)
					rad = RAD_MAX;
			end
			m.x = clamp32(cx);
			m.y = clamp32(cy);
			m.rad = rad[30:0];
			m.deg = 1'b0;
			return m;
		endfunction

		function void note_input(circle_pair_t c);
			expected_merges.push_back(predict(c));
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("mismatch on %s: got %h, expected %h (result %0d)", what, got, want,
				checked);
		endtask

		task check_result(merged_circle_t got);
			merged_circle_t want;
			if (expected_merges.size() == 0) begin
				report("unexpected result", 32'(got.x), 32'h0);
				return;
			end
			want = expected_merges.pop_front();
			if (got.x !== want.x)
				report("merged_x", got.x, want.x);
			if (got.y !== want.y)
				report("merged_y", got.y, want.y);
			if (got.rad !== want.rad)
				report("merged_radius", 32'(got.rad), 32'(want.rad));
			if (got.deg !== want.deg)
				report("degenerate", 32'(got.deg), 32'(want.deg));
			if (want.deg)
				degenerate_seen++;
			checked++;
		endtask

		function int pending();
			return expected_merges.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] center_a_x = '0;
	logic signed [31:0] center_a_y = '0;
	logic        [30:0] radius_a = '0;
	logic signed [31:0] center_b_x = '0;
	logic signed [31:0] center_b_y = '0;
	logic        [30:0] radius_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] merged_x;
	logic signed [31:0] merged_y;
	logic        [30:0] merged_radius;
	logic degenerate;

	merge_scoreboard sb = new();
	int idle_cycles = 0;
	int sent_items = 0;

	two_circle_enclosing_merge u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.center_a_x(center_a_x),
		.center_a_y(center_a_y),
		.radius_a(radius_a),
		.center_b_x(center_b_x),
		.center_b_y(center_b_y),
		.radius_b(radius_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.merged_x(merged_x),
		.merged_y(merged_y),
		.merged_radius(merged_radius),
		.degenerate(degenerate)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Present one item and hold it until accepted
	task send_pair(circle_pair_t c);
		in_valid <= 1'b1;
		center_a_x <= c.ax;
		center_a_y <= c.ay;
		radius_a <= c.ra;
		center_b_x <= c.bx;
		center_b_y <= c.by;
		radius_b <= c.rb;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_input(c);
		sent_items++;
	endtask

	function automatic circle_pair_t make_pair(logic [31:0] ax, logic [31:0] ay,
		logic [30:0] ra, logic [31:0] bx, logic [31:0] by, logic [30:0] rb);
		circle_pair_t c;
		c.ax = ax;
		c.ay = ay;
		c.ra = ra;
		c.bx = bx;
		c.by = by;
		c.rb = rb;
		return c;
	endfunction

	function automatic logic [31:0] small_coord();
		return 32'($signed($urandom_range(0, 2 ** 22)) - (2 ** 21));
	endfunction

	// Mostly well-formed geometry, with coincident, axis-aligned and extreme cases mixed in
	function automatic circle_pair_t random_pair();
		circle_pair_t c;
		int kind;
		kind = $urandom_range(0, 9);
		c = make_pair($urandom(), $urandom(), 31'($urandom()), $urandom(), $urandom(),
			31'($urandom()));
		case (kind)
			0: begin
				c.bx = c.ax;
				c.by = c.ay;
			end
			1: c.bx = c.ax;
			2: c.by = c.ay;
			3, 4, 5: begin
				c = make_pair(small_coord(), small_coord(), 31'($urandom_range(0, 2 ** 21)),
					small_coord(), small_coord(), 31'($urandom_range(0, 2 ** 21)));
				if ($urandom_range(0, 7) == 0) begin
					c.bx = c.ax;
					c.by = c.ay;
				end
			end
			6: begin
				c.ra = ($urandom_range(0, 1) != 0) ? RAD_MAX : 31'd0;
				c.rb = ($urandom_range(0, 1) != 0) ? RAD_MAX : 31'd0;
			end
			7: begin
				c.bx = c.ax + 32'($urandom_range(0, 4)) - 32'd2;
				c.by = c.ay + 32'($urandom_range(0, 4)) - 32'd2;
			end
			default: ;
		endcase
		return c;
	endfunction

	// Check each accepted result and vary the output stall pattern
	always @(posedge clk) begin
		int phase;
		if (out_valid && !out_stall)
			sb.check_result('{merged_x, merged_y, merged_radius, degenerate});
		phase = int'(($time / 800) % 4);
		case (phase)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ($urandom_range(0, 15) < 8);
		endcase
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int burst;
		int gap;
		int n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_pair(make_pair(32'h0, 32'h0, 31'h0, 32'h0, 32'h0, 31'h0));
		send_pair(make_pair(32'h1_0000, 32'h2_0000, 31'h3_0000, 32'h1_0000, 32'h2_0000,
			31'h5_0000));
		send_pair(make_pair(32'h8000_0000, 32'h8000_0000, RAD_MAX, 32'h8000_0000,
			32'h8000_0000, 31'h1));
		send_pair(make_pair(32'h0, 32'h0, 31'h1_0000, 32'h0, 32'h5_0000, 31'h2_0000));
		send_pair(make_pair(32'h0, 32'h0, 31'h1_0000, 32'h0, 32'hFFFB_0000, 31'h2_0000));
		send_pair(make_pair(32'h0, 32'h0, 31'h1_0000, 32'h5_0000, 32'h0, 31'h2_0000));
		send_pair(make_pair(32'h0, 32'h0, 31'h1_0000, 32'hFFFB_0000, 32'h0, 31'h2_0000));
		send_pair(make_pair(32'h0, 32'h0, 31'h8000, 32'h3_0000, 32'h4_0000, 31'h8000));
		send_pair(make_pair(32'h8000_0000, 32'h8000_0000, RAD_MAX, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, RAD_MAX));
		send_pair(make_pair(32'h7FFF_FFFF, 32'h8000_0000, RAD_MAX, 32'h8000_0000,
			32'h7FFF_FFFF, RAD_MAX));
		send_pair(make_pair(32'h7FFF_FFFF, 32'h0, 31'h0, 32'h8000_0000, 32'h0, 31'h0));
		send_pair(make_pair(32'h0, 32'h7FFF_FFFF, RAD_MAX, 32'h0, 32'h7FFF_FFFE, 31'h0));
		send_pair(make_pair(32'h0, 32'h0, 31'h0, 32'h1, 32'h0, 31'h0));
		send_pair(make_pair(32'h0, 32'h0, 31'h0, 32'h1, 32'h1, 31'h0));
		send_pair(make_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF, 32'h1, 32'h3, 31'h8000));
		send_pair(make_pair(32'h7FFF_0000, 32'h7FFF_0000, RAD_MAX, 32'h7FFF_0001,
			32'h7FFF_0000, RAD_MAX));
		send_pair(make_pair(32'h1234_5678, 32'hEDCB_A987, 31'h2AAA_AAAA, 32'hEDCB_A987,
			32'h1234_5678, 31'h5555_5555));
		send_pair(make_pair(32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555, 32'h5555_5555,
			32'hAAAA_AAAA, 31'h2AAA_AAAA));
		in_valid <= 1'b0;

		// hold off until the pipeline has drained
		while (sb.pending() != 0)
			@(posedge clk);

		// random bursts with random gaps
		n = 0;
		while (n < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && n < RANDOM_ITEMS; i++) begin
				send_pair(random_pair());
				n++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d circle pairs, checked %0d merges (%0d with coincident centers),",
			sent_items, sb.checked, sb.degenerate_seen);
		$display("under bursty input and varying output stalls; %0d mismatches.", sb.errors);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
